[hdl/ufec_pkg.sv]
// Package for the union-find edge classifier.
// Node count, payload structs, front/back queue entry type and back-end state codes.
// No dependencies.
package ufec_pkg;

  localparam int NODES = 1024;

  typedef struct packed {
    logic [9:0] node_a;
    logic [9:0] node_b;
  } edge_t;

  typedef struct packed {
    logic        redundant;
    logic [9:0]  root;
    logic [10:0] set_size;
    logic        bad_node;
  } result_t;

  // queue entry from front to back
  typedef struct packed {
    logic       bad;
    logic [9:0] node_a;
    logic [9:0] node_b;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_SIZE_RD,
    ST_SIZE_CHK,
    ST_MERGE,
    ST_OUT
  } be_state_t;

endpackage

[hdl/ufec_front.sv]
// Front end: takes edges, flags endpoints outside the node limit, and
// pushes jobs into a two-entry queue toward the back end. Uses ufec_pkg.
module ufec_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ufec_pkg::edge_t in_data,
  input  logic [10:0]     node_count,
  output logic            job_valid,
  output ufec_pkg::job_t  job,
  input  logic            job_take
);
  import ufec_pkg::*;

  localparam logic [16:0] NodesW = 17'(NODES);

  job_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic [16:0] limit;
  logic       push;
  job_t       nj;

  assign limit = ({6'd0, node_count} < NodesW) ? {6'd0, node_count} : NodesW;
  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign nj.bad = ({7'd0, in_data.node_a} >= limit) || ({7'd0, in_data.node_b} >= limit);
  assign nj.node_a = in_data.node_a;
  assign nj.node_b = in_data.node_b;
  assign job_valid = (fill != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (job_take) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, job_take};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= nj;
  end

endmodule

[hdl/ufec_back.sv]
// Back end: parent and size memories, root walks with path compression,
// union by size, and a result register. Clears memories after reset.
// Uses ufec_pkg.
module ufec_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  ufec_pkg::job_t    job,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_stall,
  output ufec_pkg::result_t out_data
);
  import ufec_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [AW:0] NodesW = (AW + 1)'(NODES);

  logic [9:0]  par_mem [NODES];
  logic [10:0] siz_mem [NODES];
  logic [9:0]  par_rd;
  logic [10:0] siz_rd;

  be_state_t   state, state_next;
  logic [AW:0] clr_idx;
  job_t        cur_job;
  logic        second;
  logic [9:0]  node, walk, ra, rb, rroot;
  logic [AW:0] hops;
  logic [10:0] sa, sb;
  result_t     res;

  // memory control
  logic        p_we, s_we;
  logic [AW-1:0] p_addr, s_addr;
  logic [9:0]  p_wd;
  logic [10:0] s_wd;

  always_ff @(posedge clk) begin
    if (p_we) par_mem[p_addr] <= p_wd;
    par_rd <= par_mem[p_addr];
  end
  always_ff @(posedge clk) begin
    if (s_we) siz_mem[s_addr] <= s_wd;
    siz_rd <= siz_mem[s_addr];
  end

  logic is_root;
  assign is_root = (par_rd == walk) || ({1'b0, par_rd} >= 11'(NODES)) ||
                   (hops >= NodesW);

  logic [9:0] big, small_r;
  logic       swap;
  assign swap = (sa < sb);
  assign big = swap ? rb : ra;
  assign small_r = swap ? ra : rb;

  always_comb begin
    state_next = state;
    p_we = 1'b0;
    s_we = 1'b0;
    p_addr = walk[AW-1:0];
    s_addr = ra[AW-1:0];
    p_wd = rroot;
    s_wd = 11'd1;
    job_take = 1'b0;
    case (state)
      ST_CLEAR: begin
        p_we = 1'b1;
        s_we = 1'b1;
        p_addr = clr_idx[AW-1:0];
        s_addr = clr_idx[AW-1:0];
        p_wd = 10'(clr_idx);
        if (clr_idx == NodesW - 1'b1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (job_valid && !out_valid) begin
          job_take = 1'b1;
          state_next = job.bad ? ST_OUT : ST_FIND_RD;
        end
      end
      ST_FIND_RD: state_next = ST_FIND_CHK;
      ST_FIND_CHK: state_next = is_root ? ST_COMP_RD : ST_FIND_RD;
      ST_COMP_RD: begin
        p_addr = node[AW-1:0];
        state_next = (node == rroot || hops >= NodesW) ? ST_SIZE_RD : ST_COMP_WR;
      end
      ST_COMP_WR: begin
        p_addr = node[AW-1:0];
        p_we = 1'b1;
        p_wd = rroot;
        state_next = ST_COMP_RD;
      end
      ST_SIZE_RD: begin
        s_addr = rroot[AW-1:0];
        state_next = ST_SIZE_CHK;
      end
      ST_SIZE_CHK: state_next = second ? ST_MERGE : ST_FIND_RD;
      ST_MERGE: begin
        if (ra != rb) begin
          p_we = 1'b1;
          p_addr = small_r[AW-1:0];
          p_wd = big;
          s_we = 1'b1;
          s_addr = big[AW-1:0];
          s_wd = sa + sb;
        end
        state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_OUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_job <= job;
        second <= 1'b0;
        walk <= job.node_a;
        node <= job.node_a;
        hops <= '0;
      end
      ST_FIND_CHK: begin
        if (is_root) begin
          rroot <= walk;
          hops <= '0;
        end else begin
          walk <= par_rd;
          hops <= hops + 1'b1;
        end
      end
      ST_COMP_WR: begin
        if ({1'b0, par_rd} >= 11'(NODES)) hops <= NodesW;
        else hops <= hops + 1'b1;
        node <= par_rd;
      end
      ST_SIZE_RD: begin
        if (second) rb <= rroot;
        else ra <= rroot;
      end
      ST_SIZE_CHK: begin
        if (second) sb <= siz_rd;
        else begin
          sa <= siz_rd;
          second <= 1'b1;
          walk <= cur_job.node_b;
          node <= cur_job.node_b;
          hops <= '0;
        end
      end
      ST_MERGE: begin
        res.bad_node <= 1'b0;
        res.redundant <= (ra == rb);
        res.root <= (ra == rb) ? ra : big;
        res.set_size <= (ra == rb) ? sa : sa + sb;
      end
      default: ;
    endcase
    if (job_take && job.bad) begin
      res.bad_node <= 1'b1;
      res.redundant <= 1'b0;
      res.root <= '0;
      res.set_size <= '0;
    end
  end

  assign out_data = res;

endmodule

[hdl/union_find_edge_classifier.sv]
// Top level of the union-find edge classifier.
// Joins the front end (checks, queue) and the back end (DSU memories).
// Uses ufec_pkg, ufec_front, ufec_back.
//
// Usage: edges enter on in_valid/in_stall with payload in_data (node_a,
// node_b). One result per edge leaves on out_valid/out_stall with out_data
// (redundant, root, set_size, bad_node), in edge order. node_count is
// written through cfg_valid/cfg_ready/cfg_data; the user must write it
// only while the block is idle, which the block does not enforce. A front
// queue of two entries takes edges while the back end works. Per edge the
// back end walks each endpoint to its root, relinks the path and reads the
// root's set size, then merges; a bad edge skips this. The single-port
// parent memory serializes the steps. After reset both memories are
// cleared before the first edge is processed; the queue may fill meanwhile.
// A stalled result holds out_data; the back end waits until it is taken.
module union_find_edge_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufec_pkg::edge_t     in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ufec_pkg::result_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data
);
  import ufec_pkg::*;

  logic [10:0] node_count;
  logic        job_valid, job_take;
  job_t        job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) node_count <= 11'd1024;
    else if (cfg_valid) node_count <= cfg_data;
  end

  ufec_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .node_count,
    .job_valid, .job, .job_take
  );

  ufec_back u_back (
    .clk, .rst, .job_valid, .job, .job_take, .out_valid, .out_stall, .out_data
  );

endmodule

[tb/sv/ufec_checker.sv]
// Checker for the union-find edge classifier: watches the edge, result and
// node_count channels, predicts each result with its own disjoint-set copy.
// Depends on ufec_pkg.
module ufec_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ufec_pkg::edge_t   in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  ufec_pkg::result_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [10:0]       cfg_data,
  output int                fail_count,
  output int                pending,
  output int                merges,
  output int                redundants,
  output int                bad_edges
);
  timeunit 1ns;
  timeprecision 1ps;
  import ufec_pkg::*;

  logic [9:0]  link_q [NODES];
  logic [10:0] size_q [NODES];
  logic [10:0] limit_reg;
  result_t     expected_results [$];

  function automatic logic [9:0] walk_to_root(input logic [9:0] node);
    logic [9:0] r, cur, p;
    int hops;
    r = node;
    hops = 0;
    while (hops < NODES && link_q[r] != r) begin
      r = link_q[r];
      hops++;
    end
    cur = node;
    hops = 0;
    while (cur != r && hops < NODES) begin
      p = link_q[cur];
      link_q[cur] = r;
      cur = p;
      hops++;
    end
    return r;
  endfunction

  function automatic result_t classify_edge(input edge_t e);
    result_t res;
    logic [9:0] ra, rb, t;
    res = '0;
    if ({1'b0, e.node_a} >= limit_reg || {1'b0, e.node_b} >= limit_reg) begin
      res.bad_node = 1'b1;
      bad_edges++;
      return res;
    end
    ra = walk_to_root(e.node_a);
    rb = walk_to_root(e.node_b);
    if (ra == rb) begin
      res.redundant = 1'b1;
      redundants++;
    end else begin
      if (size_q[ra] < size_q[rb]) begin
        t = ra;
        ra = rb;
        rb = t;
      end
      link_q[rb] = ra;
      size_q[ra] = size_q[ra] + size_q[rb];
      merges++;
    end
    res.root = ra;
    res.set_size = size_q[ra];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        link_q[i] = i[9:0];
        size_q[i] = 11'd1;
      end
      limit_reg = 11'd1024;
      expected_results.delete();
      fail_count = 0;
      merges = 0;
      redundants = 0;
      bad_edges = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), classify_edge(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.redundant !== out_data.redundant) begin
            $error("redundant: expected %0d actual %0d", exp_r.redundant, out_data.redundant);
            fail_count++;
          end
          if (exp_r.root !== out_data.root) begin
            $error("root: expected %0d actual %0d", exp_r.root, out_data.root);
            fail_count++;
          end
          if (exp_r.set_size !== out_data.set_size) begin
            $error("set_size: expected %0d actual %0d", exp_r.set_size, out_data.set_size);
            fail_count++;
          end
          if (exp_r.bad_node !== out_data.bad_node) begin
            $error("bad_node: expected %0d actual %0d", exp_r.bad_node, out_data.bad_node);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

[tb/sv/testbench.sv]
// Top of the union-find edge classifier testbench: clock, reset, edge and
// node_count stimulus, result stall pattern and verdict.
// Depends on ufec_pkg, union_find_edge_classifier and ufec_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ufec_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  edge_t       in_data;
  logic        out_valid;
  logic        out_stall;
  result_t     out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  int          fail_count, pending, merges, redundants, bad_edges;
  logic        hold_off;
  int          edges_sent;

  union_find_edge_classifier uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ufec_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .merges(merges),
    .redundants(redundants), .bad_edges(bad_edges)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // result stall pattern, with one long hold-off window
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 50) out_stall <= 1'b0;
        else if (mode < 80) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_edge(input logic [9:0] a, input logic [9:0] b);
    in_valid <= 1'b1;
    in_data <= '{node_a: a, node_b: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edges_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_limit(input logic [10:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] pick_node(input int span);
    if ($urandom_range(0, 19) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, span - 1));
  endfunction

  task automatic random_phase(input int count, input int span);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 20);
      end
      send_edge(pick_node(span), pick_node(span));
      burst--;
    end
    drain();
  endtask

  initial begin
    hold_off = 1'b0;
    edges_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edges at the default limit
    send_edge(10'd0, 10'd1023);
    send_edge(10'd1023, 10'd0);
    send_edge(10'd5, 10'd5);
    send_edge(10'd2, 10'd3);
    send_edge(10'd3, 10'd0);
    send_edge(10'd1, 10'd2);
    send_edge(10'd4, 10'd5);
    send_edge(10'd6, 10'd4);
    send_edge(10'd4, 10'd2);
    send_edge(10'd6, 10'd1);
    send_edge(10'h155, 10'h2AA);
    send_edge(10'h2AA, 10'h155);
    drain();

    // lowered limit: old sets kept, high nodes flagged
    write_limit(11'd8);
    send_edge(10'd7, 10'd8);
    send_edge(10'd8, 10'd7);
    send_edge(10'd7, 10'd0);
    send_edge(10'd1023, 10'd1023);
    drain();
    write_limit(11'd0);
    send_edge(10'd0, 10'd0);
    send_edge(10'd3, 10'd1);
    drain();
    write_limit(11'd1);
    send_edge(10'd0, 10'd0);
    send_edge(10'd0, 10'd1);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_limit(11'd64);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(30, 64);
    join

    write_limit(11'd1024);
    random_phase(200, 1024);
    write_limit(11'd2047);
    random_phase(150, 64);
    write_limit(11'd300);
    random_phase(150, 300);
    write_limit(11'd16);
    random_phase(100, 16);

    $display("edges sent %0d: %0d merges, %0d redundant, %0d flagged",
             edges_sent, merges, redundants, bad_edges);
    $display("node_count settings 0, 1, 8, 16, 64, 300, 1024 and 2047 used");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
